// ===== hdl/carpid_pkg.sv =====
// ----------------------------------------------------------------------------
// Cascaded angle/rate PID package
// Types, register indexes and fixed limits shared by the controller core.
// ----------------------------------------------------------------------------
package carpid_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_P  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_I  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_D  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN_P = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN_D = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TARGET = 3'd6;

  // Request kinds carried in tuser.
  localparam logic REQ_ANGLE = 1'b0;
  localparam logic REQ_RATE  = 1'b1;

  // Integral separation threshold (70.0 in Q17.8), on the 26-bit error.
  localparam logic signed [25:0] SEP_LIMIT   = 26'sd17920;
  localparam logic signed [25:0] SEP_LIMIT_N = -26'sd17920;

  // Integral sum clamp (7000.0), on the 27-bit raw sum.
  localparam logic signed [26:0] SUM_LIMIT   = 27'sd1792000;
  localparam logic signed [26:0] SUM_LIMIT_N = -27'sd1792000;

  // Output clamps (300.0 and 100.0), on the 37-bit shifted accumulator.
  localparam logic signed [36:0] DRIVE_LIMIT   = 37'sd76800;
  localparam logic signed [36:0] DRIVE_LIMIT_N = -37'sd76800;
  localparam logic signed [36:0] RATE_LIMIT    = 37'sd25600;
  localparam logic signed [36:0] RATE_LIMIT_N  = -37'sd25600;

  // Derivative filter weights in 1/256 units.
  localparam logic signed [15:0] W_NEW = 16'sd51;
  localparam logic signed [15:0] W_OLD = 16'sd205;

  // Sequencer states, one-hot.
  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_PREP    = 12'b0000_0000_0010,
    ST_DIFF    = 12'b0000_0000_0100,
    ST_F_NEW   = 12'b0000_0000_1000,
    ST_F_OLD   = 12'b0000_0001_0000,
    ST_F_SUM   = 12'b0000_0010_0000,
    ST_F_STORE = 12'b0000_0100_0000,
    ST_K_P     = 12'b0000_1000_0000,
    ST_K_D     = 12'b0001_0000_0000,
    ST_K_I     = 12'b0010_0000_0000,
    ST_ACC     = 12'b0100_0000_0000,
    ST_FIN     = 12'b1000_0000_0000
  } seq_state_t;

endpackage

// ===== hdl/cascaded_angle_rate_pid_core.sv =====
// ----------------------------------------------------------------------------
// Cascaded angle/rate PID core
// Outer angle loop feeding a rate setpoint to an inner PID with integral
// separation and a filtered derivative, on one shared 26x16 multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Content
//  s_*       in         s_tvalid/s_tready   request word: measured value, rate feedback,
//                                           request kind in tuser
//  m_*       out        m_tvalid/m_tready   result word: drive, rate target
//  cfg_*     in         cfg_we              register index and write data
//
// An angle request steps through PREP, K_P, K_D, K_I, ACC and FIN; a rate request
// through PREP, DIFF, F_NEW, F_OLD, F_SUM, F_STORE (which also forms the P product),
// K_D, K_I, ACC and FIN. The single multiplier and its product register set the
// step count. Only one request is in flight; s_tready is high while the sequencer
// is idle, also while a finished result still waits in the output register. If the
// output register is full and not being drained, the sequencer holds in its final
// step. Reset (synchronous) clears the loop state, configuration, sequencer and m_tvalid.
//
module cascaded_angle_rate_pid_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [47:0]                           s_tdata,  // measured_value[23:0], rate_feedback[47:24]
  input  logic [0:0]                            s_tuser,  // req_type[0]
  // Result stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [39:0]                           m_tdata,  // drive[17:0], rate_target[33:18], zero fill
  // Configuration writes.
  input  logic                                  cfg_we,
  input  logic [carpid_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [carpid_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic signed [15:0] rate_gain_p;
  logic signed [15:0] rate_gain_i;
  logic signed [15:0] rate_gain_d;
  logic signed [15:0] angle_gain_p;
  logic signed [15:0] angle_gain_d;
  logic signed [23:0] zero_offset;
  logic signed [23:0] angle_target;

  // Loop state.
  logic signed [15:0] rate_setpoint;
  logic signed [25:0] previous_error;
  logic signed [21:0] error_sum;
  logic signed [25:0] filtered_derivative;
  logic signed [17:0] last_drive;

  // Working registers of the current request.
  carpid_pkg::seq_state_t state, state_next;
  logic               req;
  logic signed [23:0] meas;
  logic signed [23:0] fb;
  logic signed [25:0] err;
  logic signed [25:0] diff;
  logic               in_band;
  logic signed [41:0] prod;
  logic signed [44:0] acc;

  // Combinational helpers.
  logic signed [25:0] outer_err;
  logic signed [25:0] inner_err;
  logic signed [25:0] diff_calc;
  logic               inside_calc;
  logic signed [26:0] sum_raw;
  logic signed [21:0] sum_clamped;
  logic signed [44:0] prod_ext;
  logic signed [36:0] acc_shr;
  logic signed [17:0] drive_clamped;
  logic signed [15:0] rate_clamped;
  logic signed [25:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [41:0] mul_p;
  logic               out_free;

  assign s_tready = (state == carpid_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Configuration register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_gain_p  <= '0;
      rate_gain_i  <= '0;
      rate_gain_d  <= '0;
      angle_gain_p <= '0;
      angle_gain_d <= '0;
      zero_offset  <= '0;
      angle_target <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        carpid_pkg::REG_RATE_GAIN_P:  rate_gain_p  <= cfg_wdata[15:0];
        carpid_pkg::REG_RATE_GAIN_I:  rate_gain_i  <= cfg_wdata[15:0];
        carpid_pkg::REG_RATE_GAIN_D:  rate_gain_d  <= cfg_wdata[15:0];
        carpid_pkg::REG_ANGLE_GAIN_P: angle_gain_p <= cfg_wdata[15:0];
        carpid_pkg::REG_ANGLE_GAIN_D: angle_gain_d <= cfg_wdata[15:0];
        carpid_pkg::REG_ZERO_OFFSET:  zero_offset  <= cfg_wdata;
        carpid_pkg::REG_ANGLE_TARGET: angle_target <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Error terms; all values fit 26 bits, so wrapping arithmetic is exact.
  assign outer_err = {{2{angle_target[23]}}, angle_target} - {{2{meas[23]}}, meas}
                   + {{2{zero_offset[23]}}, zero_offset};
  assign inner_err = {{10{rate_setpoint[15]}}, rate_setpoint} - {{2{meas[23]}}, meas};
  assign diff_calc = err - previous_error;

  // Integral separation and the clamped running sum.
  assign inside_calc = (err < carpid_pkg::SEP_LIMIT) && (err > carpid_pkg::SEP_LIMIT_N);
  assign sum_raw     = {{5{error_sum[21]}}, error_sum} + {err[25], err};

  always_comb begin
    if (sum_raw > carpid_pkg::SUM_LIMIT) begin
      sum_clamped = carpid_pkg::SUM_LIMIT[21:0];
    end else if (sum_raw < carpid_pkg::SUM_LIMIT_N) begin
      sum_clamped = carpid_pkg::SUM_LIMIT_N[21:0];
    end else begin
      sum_clamped = sum_raw[21:0];
    end
  end

  // Floor shift by 8 and the output clamps.
  assign prod_ext = {{3{prod[41]}}, prod};
  assign acc_shr  = acc[44:8];

  always_comb begin
    if (acc_shr > carpid_pkg::DRIVE_LIMIT) begin
      drive_clamped = carpid_pkg::DRIVE_LIMIT[17:0];
    end else if (acc_shr < carpid_pkg::DRIVE_LIMIT_N) begin
      drive_clamped = carpid_pkg::DRIVE_LIMIT_N[17:0];
    end else begin
      drive_clamped = acc_shr[17:0];
    end
  end

  always_comb begin
    if (acc_shr > carpid_pkg::RATE_LIMIT) begin
      rate_clamped = carpid_pkg::RATE_LIMIT[15:0];
    end else if (acc_shr < carpid_pkg::RATE_LIMIT_N) begin
      rate_clamped = carpid_pkg::RATE_LIMIT_N[15:0];
    end else begin
      rate_clamped = acc_shr[15:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      carpid_pkg::ST_F_NEW: begin
        mul_a = diff;
        mul_b = carpid_pkg::W_NEW;
      end
      carpid_pkg::ST_F_OLD: begin
        mul_a = filtered_derivative;
        mul_b = carpid_pkg::W_OLD;
      end
      carpid_pkg::ST_F_STORE, carpid_pkg::ST_K_P: begin
        mul_a = err;
        mul_b = (req == carpid_pkg::REQ_RATE) ? rate_gain_p : angle_gain_p;
      end
      carpid_pkg::ST_K_D: begin
        if (req == carpid_pkg::REQ_RATE) begin
          mul_a = filtered_derivative;
          mul_b = rate_gain_d;
        end else begin
          mul_a = {{2{fb[23]}}, fb};
          mul_b = angle_gain_d;
        end
      end
      carpid_pkg::ST_K_I: begin
        // The integral term is dropped outside the separation band.
        if ((req == carpid_pkg::REQ_RATE) && in_band) begin
          mul_a = {{4{error_sum[21]}}, error_sum};
          mul_b = rate_gain_i;
        end
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      carpid_pkg::ST_IDLE:    if (s_tvalid) state_next = carpid_pkg::ST_PREP;
      carpid_pkg::ST_PREP:    state_next = (req == carpid_pkg::REQ_RATE) ?
                                           carpid_pkg::ST_DIFF : carpid_pkg::ST_K_P;
      carpid_pkg::ST_DIFF:    state_next = carpid_pkg::ST_F_NEW;
      carpid_pkg::ST_F_NEW:   state_next = carpid_pkg::ST_F_OLD;
      carpid_pkg::ST_F_OLD:   state_next = carpid_pkg::ST_F_SUM;
      carpid_pkg::ST_F_SUM:   state_next = carpid_pkg::ST_F_STORE;
      carpid_pkg::ST_F_STORE: state_next = carpid_pkg::ST_K_D;
      carpid_pkg::ST_K_P:     state_next = carpid_pkg::ST_K_D;
      carpid_pkg::ST_K_D:     state_next = carpid_pkg::ST_K_I;
      carpid_pkg::ST_K_I:     state_next = carpid_pkg::ST_ACC;
      carpid_pkg::ST_ACC:     state_next = carpid_pkg::ST_FIN;
      carpid_pkg::ST_FIN:     if (out_free) state_next = carpid_pkg::ST_IDLE;
      default:                state_next = carpid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= carpid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture, datapath steps and loop state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_setpoint       <= '0;
      previous_error      <= '0;
      error_sum           <= '0;
      filtered_derivative <= '0;
      last_drive          <= '0;
    end else begin
      case (state)
        carpid_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            req  <= s_tuser[0];
            meas <= s_tdata[23:0];
            fb   <= s_tdata[47:24];
          end
        end
        carpid_pkg::ST_PREP: begin
          err <= (req == carpid_pkg::REQ_RATE) ? inner_err : outer_err;
        end
        carpid_pkg::ST_DIFF: begin
          diff    <= diff_calc;
          in_band <= inside_calc;
          error_sum <= inside_calc ? sum_clamped : '0;
        end
        carpid_pkg::ST_F_NEW: begin
          prod <= mul_p;
        end
        carpid_pkg::ST_F_OLD: begin
          acc  <= prod_ext;
          prod <= mul_p;
        end
        carpid_pkg::ST_F_SUM: begin
          acc <= acc + prod_ext;
        end
        carpid_pkg::ST_F_STORE: begin
          filtered_derivative <= acc_shr[25:0];
          previous_error      <= err;
          prod                <= mul_p;
        end
        carpid_pkg::ST_K_P: begin
          prod <= mul_p;
        end
        carpid_pkg::ST_K_D: begin
          acc  <= prod_ext;
          prod <= mul_p;
        end
        carpid_pkg::ST_K_I: begin
          acc  <= acc + prod_ext;
          prod <= mul_p;
        end
        carpid_pkg::ST_ACC: begin
          acc <= acc + prod_ext;
        end
        carpid_pkg::ST_FIN: begin
          if (out_free) begin
            if (req == carpid_pkg::REQ_RATE) begin
              last_drive <= drive_clamped;
            end else begin
              rate_setpoint <= rate_clamped;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: loaded at the final step, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == carpid_pkg::ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == carpid_pkg::ST_FIN) && out_free) begin
      if (req == carpid_pkg::REQ_RATE) begin
        m_tdata <= {6'b0, rate_setpoint, drive_clamped};
      end else begin
        m_tdata <= {6'b0, rate_clamped, last_drive};
      end
    end
  end

  // The integral sum never leaves its clamp band.
  a_sum_bounded: assert property (@(posedge clk) disable iff (rst)
    (error_sum <= carpid_pkg::SUM_LIMIT) && (error_sum >= carpid_pkg::SUM_LIMIT_N))
    else $error("error_sum outside its clamp band");

  // Stored outputs stay inside their clamps.
  a_drive_bounded: assert property (@(posedge clk) disable iff (rst)
    (last_drive <= carpid_pkg::DRIVE_LIMIT) &&
    (last_drive >= carpid_pkg::DRIVE_LIMIT_N))
    else $error("last_drive outside +/-300");

  a_rate_bounded: assert property (@(posedge clk) disable iff (rst)
    (rate_setpoint <= carpid_pkg::RATE_LIMIT) &&
    (rate_setpoint >= carpid_pkg::RATE_LIMIT_N))
    else $error("rate_setpoint outside +/-100");

  // An accepted request starts the sequencer on the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == carpid_pkg::ST_PREP))
    else $error("accepted request did not start the sequencer");

  // Finishing a request always leaves a result in the output register.
  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    ((state == carpid_pkg::ST_FIN) && out_free) |=>
      (m_tvalid && (state == carpid_pkg::ST_IDLE)))
    else $error("finished request produced no result word");

endmodule
